// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the cache directory block.
// Depends on nothing; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SACF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SACF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sacf_pkg.sv -----
// Package of the set-associative cache directory: sequencer states, directory
// operations, register indexes, reset values and field widths. Depends on nothing.
package sacf_pkg;

	localparam int ADDR_W  = 32;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 32;
	localparam int REG_W   = 4;
	localparam int RC_W    = 4;
	localparam int CIDX_W  = 2;

	localparam logic [CIDX_W-1:0] CFG_SET_BITS    = 2'd0;
	localparam logic [CIDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
	localparam logic [CIDX_W-1:0] CFG_WAYS        = 2'd2;
	localparam logic [CIDX_W-1:0] CFG_PREFETCH    = 2'd3;

	localparam logic [REG_W-1:0] RST_SET_BITS    = 4'd0;
	localparam logic [REG_W-1:0] RST_OFFSET_BITS = 4'd6;
	localparam logic [REG_W-1:0] RST_WAYS        = 4'd1;
	localparam logic [REG_W-1:0] RST_PREFETCH    = 4'd0;

	localparam logic [CNT_W-1:0]   CNT_MAX     = '1;
	localparam logic [STAMP_W-1:0] STAMP_RESET = 32'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_EVAL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		DIR_NOP,
		DIR_READ,
		DIR_FILL,
		DIR_CLEAR
	} dir_op_t;

endpackage

// ----- rtl/sacf_dir.sv -----
// Directory memory: one row per set holding valid, tag and stamp of every way,
// with tag compare and FIFO victim choice on the registered row. Uses sacf_pkg.
module sacf_dir #(
	parameter int MAX_SETS  = 256,
	parameter int MAX_WAYS  = 8,
	parameter int ADDR_BITS = 32,
	parameter int SET_W     = 8,
	parameter int NW_W      = 4
) (
	input  logic                     clk,
	input  sacf_pkg::dir_op_t        op,
	input  logic [SET_W-1:0]         set_idx,
	input  logic [ADDR_BITS-1:0]     tag,
	input  logic [NW_W-1:0]          nw,
	input  logic [sacf_pkg::STAMP_W-1:0] stamp,
	output logic                     hit
);
	import sacf_pkg::*;

	localparam int ENT_W = 1 + ADDR_BITS + STAMP_W;
	localparam int ROW_W = MAX_WAYS * ENT_W;
	localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

	logic [ROW_W-1:0] mem_q [MAX_SETS];
	logic [ROW_W-1:0] row_s1;
	logic [SET_W-1:0] set_s1;

	logic [MAX_WAYS-1:0]                ent_v;
	logic [MAX_WAYS-1:0][ADDR_BITS-1:0] ent_tag;
	logic [MAX_WAYS-1:0][STAMP_W-1:0]   ent_stamp;
	logic [WAY_W-1:0]                   pick;
	logic [ROW_W-1:0]                   fill_row;

	// Read one row a cycle on a read command; write the filled or cleared row
	always_ff @(posedge clk) begin
		if (op == DIR_FILL) begin
			mem_q[set_s1] <= fill_row;
		end else if (op == DIR_CLEAR) begin
			mem_q[set_idx] <= '0;
		end
		if (op == DIR_READ) begin
			row_s1 <= mem_q[set_idx];
			set_s1 <= set_idx;
		end
	end

	// Unpack the registered row
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			ent_v[w]     = row_s1[w*ENT_W + ENT_W - 1];
			ent_tag[w]   = row_s1[w*ENT_W + STAMP_W +: ADDR_BITS];
			ent_stamp[w] = row_s1[w*ENT_W +: STAMP_W];
		end
	end

	// Compare tags over the ways in use
	always_comb begin
		hit = 1'b0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < int'(nw) && ent_v[w] && ent_tag[w] == tag) begin
				hit = 1'b1;
			end
		end
	end

	// Pick first invalid way, else oldest stamp with ties to the lowest way
	always_comb begin
		logic               found;
		logic [STAMP_W-1:0] oldest;
		found  = 1'b0;
		pick   = '0;
		oldest = ent_stamp[0];
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (w < int'(nw) && !ent_v[w] && !found) begin
				pick  = WAY_W'(w);
				found = 1'b1;
			end
		end
		if (!found) begin
			for (int w = 1; w < MAX_WAYS; w++) begin
				if (w < int'(nw) && ent_stamp[w] < oldest) begin
					oldest = ent_stamp[w];
					pick   = WAY_W'(w);
				end
			end
		end
	end

	// Replace the victim entry
	always_comb begin
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAY_W'(w) == pick) begin
				fill_row[w*ENT_W +: ENT_W] = {1'b1, tag, stamp};
			end else begin
				fill_row[w*ENT_W +: ENT_W] = row_s1[w*ENT_W +: ENT_W];
			end
		end
	end

endmodule

// ----- rtl/set_assoc_cache_fifo_prefetch_unit.sv -----
// Channel   Handshake              Payload
// in        in_valid / in_stall    req_type, address
// out       out_valid / out_stall  hit, reads_caused, writes_caused, *_total
// cfg       cfg_we                 cfg_index, cfg_data
// Each lookup reads a row of the directory (ST_LOOK), then compares tags and
// fills on a miss (ST_EVAL). A demand hit ends the access; a demand miss goes
// on with one lookup per prefetched block up to the prefetch depth. After
// reset a clearing pass over all MAX_SETS sets zeroes the directory; no beat
// is taken meanwhile. A stalled result holds; the next beat is taken once the
// sequencer is idle, so not while one is in flight, and its result waits until
// the output register is free.
// Top level of the cache directory; uses sacf_pkg, sacf_dir, assert_macros.svh.
`include "assert_macros.svh"
module set_assoc_cache_fifo_prefetch_unit #(
	parameter int MAX_SETS     = 256,
	parameter int MAX_WAYS     = 8,
	parameter int MAX_PREFETCH = 8,
	parameter int ADDR_BITS    = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [sacf_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [sacf_pkg::REG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         req_type,
	input  logic [sacf_pkg::ADDR_W-1:0]  address,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         hit,
	output logic [sacf_pkg::RC_W-1:0]    reads_caused,
	output logic                         writes_caused,
	output logic [sacf_pkg::CNT_W-1:0]   hit_total,
	output logic [sacf_pkg::CNT_W-1:0]   miss_total,
	output logic [sacf_pkg::CNT_W-1:0]   read_total,
	output logic [sacf_pkg::CNT_W-1:0]   write_total
);
	import sacf_pkg::*;

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int SB_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int NW_W   = $clog2(MAX_WAYS + 1);
	localparam int PF_W   = (MAX_PREFETCH > 0) ? $clog2(MAX_PREFETCH + 1) : 1;
	localparam int RD_W   = $clog2(MAX_PREFETCH + 2);

	state_t state_q, state_d;
	dir_op_t dir_op;

	logic [REG_W-1:0] set_bits_q, offset_bits_q, ways_q, depth_q;
	logic [REG_W-1:0] sb_eff;
	logic [NW_W-1:0]  nw_eff;
	logic [PF_W-1:0]  depth_eff;

	logic [SET_W-1:0]     clr_q;
	logic [ADDR_BITS-1:0] cur_addr_q;
	logic                 is_write_q;
	logic                 demand_q;
	logic                 hit_q;
	logic [PF_W-1:0]      pf_idx_q;
	logic [RD_W-1:0]      reads_q;
	logic [STAMP_W-1:0]   clock_q;
	logic [CNT_W-1:0]     hit_cnt_q, miss_cnt_q, read_cnt_q, write_cnt_q;
	logic                 out_valid_q, out_hit_q, out_write_q;
	logic [RD_W-1:0]      out_reads_q;

	logic [ADDR_BITS-1:0] blk, step, tag;
	logic [SET_W-1:0]     set_idx, dir_set;
	logic                 dir_hit;
	logic                 last_lookup;
	logic                 out_load;
	logic [CNT_W:0]       read_sum;

	// Clamp the set-bits, ways and prefetch registers to the built sizes
	always_comb begin
		sb_eff = (int'(set_bits_q) > SB_MAX) ? REG_W'(SB_MAX) : set_bits_q;
		if (ways_q == '0) begin
			nw_eff = NW_W'(1);
		end else if (int'(ways_q) > MAX_WAYS) begin
			nw_eff = NW_W'(MAX_WAYS);
		end else begin
			nw_eff = NW_W'(ways_q);
		end
		depth_eff = (int'(depth_q) > MAX_PREFETCH) ? PF_W'(MAX_PREFETCH)
		                                           : PF_W'(depth_q);
	end

	// Split the current address into set, tag and block step; pick the directory set
	always_comb begin
		blk     = cur_addr_q >> offset_bits_q;
		set_idx = SET_W'(blk & ((ADDR_BITS'(1) << sb_eff) - ADDR_BITS'(1)));
		tag     = blk >> sb_eff;
		step    = ADDR_BITS'(1) << offset_bits_q;
		dir_set = (state_q == ST_CLEAR) ? clr_q : set_idx;
	end

	sacf_dir #(
		.MAX_SETS (MAX_SETS),
		.MAX_WAYS (MAX_WAYS),
		.ADDR_BITS(ADDR_BITS),
		.SET_W    (SET_W),
		.NW_W     (NW_W)
	) u_dir (
		.clk    (clk),
		.op     (dir_op),
		.set_idx(dir_set),
		.tag    (tag),
		.nw     (nw_eff),
		.stamp  (clock_q),
		.hit    (dir_hit)
	);

	assign last_lookup = demand_q ? (depth_eff == '0) : (pf_idx_q == depth_eff);
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign read_sum    = {1'b0, read_cnt_q} + (CNT_W + 1)'(reads_q);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == SET_W'(MAX_SETS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_EVAL;
			ST_EVAL: begin
				if ((demand_q && dir_hit) || last_lookup) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_LOOK;
				end
			end
			ST_DONE:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// Directory command and input stall
	always_comb begin
		dir_op   = DIR_NOP;
		in_stall = 1'b1;
		case (state_q)
			ST_CLEAR: dir_op = DIR_CLEAR;
			ST_IDLE:  in_stall = 1'b0;
			ST_LOOK:  dir_op = DIR_READ;
			ST_EVAL:  if (!dir_hit) dir_op = DIR_FILL;
			ST_DONE:  dir_op = DIR_NOP;
			default:  dir_op = DIR_NOP;
		endcase
	end

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q    <= RST_SET_BITS;
			offset_bits_q <= RST_OFFSET_BITS;
			ways_q        <= RST_WAYS;
			depth_q       <= RST_PREFETCH;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_BITS:    set_bits_q    <= cfg_data;
				CFG_OFFSET_BITS: offset_bits_q <= cfg_data;
				CFG_WAYS:        ways_q        <= cfg_data;
				CFG_PREFETCH:    depth_q       <= cfg_data;
				default:         ;
			endcase
		end
	end

	// Advance the sequencer, stamp clock and totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			clock_q     <= STAMP_RESET;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			read_cnt_q  <= '0;
			write_cnt_q <= '0;
			out_valid_q <= 1'b0;
			demand_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + SET_W'(1);
			if (state_q == ST_IDLE && in_valid) demand_q <= 1'b1;
			if (state_q == ST_EVAL) begin
				demand_q <= 1'b0;
				if (!dir_hit) clock_q <= clock_q + STAMP_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (hit_q) begin
					if (hit_cnt_q != CNT_MAX) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
				end else begin
					if (miss_cnt_q != CNT_MAX) miss_cnt_q <= miss_cnt_q + CNT_W'(1);
				end
				read_cnt_q <= read_sum[CNT_W] ? CNT_MAX : read_sum[CNT_W-1:0];
				if (is_write_q && write_cnt_q != CNT_MAX) begin
					write_cnt_q <= write_cnt_q + CNT_W'(1);
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the access and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cur_addr_q <= ADDR_BITS'(address);
			is_write_q <= req_type;
			reads_q    <= '0;
			pf_idx_q   <= '0;
		end
		if (state_q == ST_EVAL) begin
			if (demand_q) hit_q <= dir_hit;
			if (!dir_hit) reads_q <= reads_q + RD_W'(1);
			cur_addr_q <= cur_addr_q + step;
			pf_idx_q   <= demand_q ? PF_W'(1) : pf_idx_q + PF_W'(1);
		end
		if (out_load) begin
			out_hit_q   <= hit_q;
			out_reads_q <= reads_q;
			out_write_q <= is_write_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign reads_caused  = RC_W'(out_reads_q);
	assign writes_caused = out_write_q;
	assign hit_total     = hit_cnt_q;
	assign miss_total    = miss_cnt_q;
	assign read_total    = read_cnt_q;
	assign write_total   = write_cnt_q;

	`SACF_ASSERT_NEXT(a_accept_starts_lookup, (in_valid && !in_stall), (state_q == ST_LOOK), "accepted beat did not start a lookup")
	`SACF_ASSERT_NOW(a_hit_no_reads, (state_q == ST_DONE && hit_q), (reads_q == '0), "demand hit caused memory reads")
	`SACF_ASSERT_NOW(a_reads_bound, (state_q == ST_DONE), (int'(reads_q) <= int'(depth_eff) + 1), "more fills than prefetch depth allows")

endmodule
